// File: sv/crcfr_pkg.sv
// Shared types and constants of the CRC-8 command frame receiver.
// Used by the register block, the frame parser, the core and the checker.
// Depends on nothing.
package crcfr_pkg;

  // Longest payload that a frame may announce; a larger length byte is dropped.
  localparam logic [7:0] MAX_PAYLOAD = 8'd32;
  // CRC-8 generator polynomial without the top bit.
  localparam logic [7:0] CRC_POLY = 8'h07;
  // Number of payload bytes kept for a command.
  localparam int CMD_BYTES = 5;

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  CMD_TYPE_RST     = 8'h01;
  localparam logic [7:0]  YAW_MASK_RST     = 8'h01;
  localparam logic [7:0]  ODO_MASK_RST     = 8'h02;
  localparam logic [15:0] TIMEOUT_RST      = 16'd50;

  typedef enum logic [2:0] {
    REG_START_MARKER = 3'd0,
    REG_CMD_TYPE     = 3'd1,
    REG_YAW_MASK     = 3'd2,
    REG_ODO_MASK     = 3'd3,
    REG_TIMEOUT      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_BODY = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_CRC_ERR  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_OVERLONG = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  cmd_type;
    logic [7:0]  yaw_mask;
    logic [7:0]  odo_mask;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic signed [7:0] direction;
    logic [7:0]        speed;
    logic [7:0]        servo;
    logic [7:0]        led_mode;
    logic              reset_heading;
    logic              reset_odometer;
  } result_t;

endpackage

// File: sv/crc8_command_frame_receiver_core.sv
// Top level of the CRC-8 command frame receiver: input register, parser, result register.
// Depends on crcfr_pkg, crcfr_cfg and crcfr_parser.
//
//   channel | direction | contents
//   in_     | slave     | tuser: mode; tdata: rx_byte
//   out_    | master    | tuser: status; tdata: command fields
//   cfg_    | APB slave | five registers at byte addresses 0, 4, 8, 12, 16
//
// One item per clock while the result is not stalled: an accepted item is held in the input
// register, and the parser updates its state and the result register when it advances out.
// The input register and the result register lie between an input transfer and its result;
// the CRC byte update and header checks are combinational. Reset is synchronous and clears
// all control state. A stalled result holds the input register only when both are full.
module crc8_command_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] direction, [15:8] speed, [23:16] servo,
                                  // [31:24] led_mode, [32] reset_heading,
                                  // [33] reset_odometer, [39:34] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import crcfr_pkg::*;

  cfg_t       cfg;
  logic       in_valid_r, in_valid_nxt;
  logic       in_mode_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  crcfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // The held item moves on whenever the result register is free or being emptied.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = rst_n & (~in_valid_r | advance);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (advance)           in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else        in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  crcfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .mode       (in_mode_r),
    .rx_byte    (in_byte_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = res_valid;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.reset_odometer, out_res_r.reset_heading,
                       out_res_r.led_mode, out_res_r.servo, out_res_r.speed,
                       out_res_r.direction};

endmodule

// File: sv/crcfr_cfg.sv
// Configuration register block with an APB-style write and read port.
// Depends on crcfr_pkg for the register indexes, reset values and cfg_t.
module crcfr_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output crcfr_pkg::cfg_t      cfg
);
  import crcfr_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_MARKER: cfg_nxt.start_marker  = pwdata[7:0];
        REG_CMD_TYPE:     cfg_nxt.cmd_type      = pwdata[7:0];
        REG_YAW_MASK:     cfg_nxt.yaw_mask      = pwdata[7:0];
        REG_ODO_MASK:     cfg_nxt.odo_mask      = pwdata[7:0];
        REG_TIMEOUT:      cfg_nxt.timeout_ticks = pwdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker  <= START_MARKER_RST;
      cfg_r.cmd_type      <= CMD_TYPE_RST;
      cfg_r.yaw_mask      <= YAW_MASK_RST;
      cfg_r.odo_mask      <= ODO_MASK_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_MARKER: prdata = {24'd0, cfg_r.start_marker};
      REG_CMD_TYPE:     prdata = {24'd0, cfg_r.cmd_type};
      REG_YAW_MASK:     prdata = {24'd0, cfg_r.yaw_mask};
      REG_ODO_MASK:     prdata = {24'd0, cfg_r.odo_mask};
      REG_TIMEOUT:      prdata = {16'd0, cfg_r.timeout_ticks};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: sv/crcfr_parser.sv
// Frame parser: phase state machine, running CRC-8, payload store and timeout counter.
// Depends on crcfr_pkg; consumes one registered item per cycle and reports a result.
module crcfr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  logic                 mode,
  input  logic [7:0]           rx_byte,
  input  crcfr_pkg::cfg_t      cfg,
  output logic                 res_valid,
  output crcfr_pkg::result_t   res
);
  import crcfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [5:0]  flen_r, flen_nxt;
  logic [5:0]  seen_r, seen_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  cb_r [CMD_BYTES];
  logic        cb_we;
  logic [2:0]  cb_idx;
  logic [5:0]  seen_inc;
  logic [7:0]  flags;

  // One byte of CRC-8, MSB first, processed bit by bit.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  assign seen_inc = seen_r + 6'd1;
  assign cb_idx   = seen_r[2:0];
  // The flag byte only exists in a five-byte command.
  assign flags    = (flen_r == 6'd5) ? cb_r[4] : 8'd0;

  always_comb begin
    phase_nxt = phase_r;
    ftype_nxt = ftype_r;
    flen_nxt  = flen_r;
    seen_nxt  = seen_r;
    crc_nxt   = crc_r;
    idle_nxt  = idle_r;
    cb_we     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (item_valid) begin
      if (mode) begin
        // Ticks only count while the body or the check byte is awaited.
        if (phase_r == PH_BODY || phase_r == PH_CRC) begin
          if (idle_r >= cfg.timeout_ticks) begin
            phase_nxt  = PH_HUNT;
            res_valid  = 1'b1;
            res.status = ST_TIMEOUT;
          end else begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (rx_byte == cfg.start_marker) phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            ftype_nxt = rx_byte;
            crc_nxt   = crc8_byte(8'd0, rx_byte);
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte > MAX_PAYLOAD) begin
              phase_nxt  = PH_HUNT;
              res_valid  = 1'b1;
              res.status = ST_OVERLONG;
            end else begin
              flen_nxt  = rx_byte[5:0];
              crc_nxt   = crc8_byte(crc_r, rx_byte);
              seen_nxt  = 6'd0;
              idle_nxt  = 16'd0;
              phase_nxt = (rx_byte[5:0] == 6'd0) ? PH_CRC : PH_BODY;
            end
          end
          PH_BODY: begin
            cb_we    = (seen_r < 6'(CMD_BYTES));
            crc_nxt  = crc8_byte(crc_r, rx_byte);
            seen_nxt = seen_inc;
            if (seen_inc >= flen_r) phase_nxt = PH_CRC;
          end
          PH_CRC: begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            if (rx_byte != crc_r) begin
              res.status = ST_CRC_ERR;
            end else if (ftype_r == cfg.cmd_type &&
                         (flen_r == 6'd4 || flen_r == 6'd5)) begin
              res.status         = ST_ACCEPTED;
              res.direction      = cb_r[0];
              res.speed          = cb_r[1];
              res.servo          = cb_r[2];
              res.led_mode       = cb_r[3];
              res.reset_heading  = |(flags & cfg.yaw_mask);
              res.reset_odometer = |(flags & cfg.odo_mask);
            end else begin
              res.status = ST_IGNORED;
            end
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      ftype_r <= 8'd0;
      flen_r  <= 6'd0;
      seen_r  <= 6'd0;
      crc_r   <= 8'd0;
      idle_r  <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      ftype_r <= ftype_nxt;
      flen_r  <= flen_nxt;
      seen_r  <= seen_nxt;
      crc_r   <= crc_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cb_we) cb_r[cb_idx] <= rx_byte;
  end

endmodule

// File: sv/crcfr_checker.sv
// Port-level checker for the CRC-8 command frame receiver, bound to the top level.
// Depends on crcfr_pkg for the status codes.
module crcfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import crcfr_pkg::*;

  // No result may be offered in the cycle after a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or vanished");

  // Only an accepted command carries payload fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_ACCEPTED |-> out_tdata == 40'd0)
    else $error("non-command result carries payload");

  // A fresh result must follow an earlier input transfer.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without a matching input transfer");

endmodule

bind crc8_command_frame_receiver_core crcfr_checker u_crcfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
